// ===== design/bddc_pkg.sv =====
// ----------------------------------------------------------------------------
// bddc_pkg
// Shared types and constants of the box delta decode and clip unit.
// ----------------------------------------------------------------------------
package bddc_pkg;

   // Register indexes of the control port.
   typedef enum logic [1:0] {
      CSR_IMAGE_ROWS   = 2'd0,
      CSR_IMAGE_COLS   = 2'd1,
      CSR_MIN_BOX_SIZE = 2'd2
   } csr_index_type;

   localparam logic [12:0] IMAGE_ROWS_RESET   = 13'd480;
   localparam logic [12:0] IMAGE_COLS_RESET   = 13'd640;
   localparam logic [11:0] MIN_BOX_SIZE_RESET = 12'd32;

   // Pipeline depth: seven stages per axis plus the size check at the output.
   localparam int AXIS_STAGES = 7;
   localparam int NUM_STAGES  = AXIS_STAGES + 1;

   // log2(e) with 16 fraction bits.
   localparam logic signed [17:0] LOG2E_Q16 = 18'sd94548;

   // 2^(k/16) with 16 fraction bits, k = 0..16.
   localparam logic [17:0] EXP2_TAB [17] = '{
      18'd65536,  18'd68438,  18'd71468,  18'd74632,  18'd77936,  18'd81386,
      18'd84990,  18'd88752,  18'd92682,  18'd96785,  18'd101070, 18'd105545,
      18'd110218, 18'd115098, 18'd120194, 18'd125515, 18'd131072
   };

   // Stage enables handed from the flow control to an axis datapath.
   typedef struct packed {
      logic [AXIS_STAGES-1:0] en;
   } axis_ctl_type;

endpackage

// ===== design/bddc_axis.sv =====
// ----------------------------------------------------------------------------
// bddc_axis
// Seven-stage datapath that decodes one axis of a box and clips its edges.
// ----------------------------------------------------------------------------
module bddc_axis #(
   parameter int DELTA_FRAC_BITS = 12
) (
   input  logic                   clock,
   input  bddc_pkg::axis_ctl_type ctl,
   input  logic [11:0]            prop_lo,
   input  logic [11:0]            prop_hi,
   input  logic signed [15:0]     delta_ctr,
   input  logic signed [15:0]     delta_log,
   input  logic [12:0]            bound,
   output logic signed [15:0]     box_lo,
   output logic signed [15:0]     box_hi
);

   localparam int F  = DELTA_FRAC_BITS;
   localparam int CW = F + 24;        // centre numerator
   localparam int PW = 47;            // exp times size
   localparam int NW = F + 47;        // edge numerator
   localparam int EW = NW - F - 16;   // edge before clipping
   localparam logic [NW-1:0] RND = NW'((64'd1 << (F + 16)) - 64'd1);

   // Stage 1: log product, centre shift product, size and sum.
   logic signed [33:0] prod_ff, prod_in;
   logic signed [29:0] cm_ff, cm_in;
   logic signed [13:0] size1_ff, size_in;
   logic [12:0]        sum_ff, sum_in;

   assign size_in = 14'($signed({2'b00, prop_hi}) - $signed({2'b00, prop_lo}) + 14'sd1);
   assign sum_in  = {1'b0, prop_lo} + {1'b0, prop_hi};
   assign prod_in = delta_log * bddc_pkg::LOG2E_Q16;
   assign cm_in   = delta_ctr * size_in;

   always_ff @(posedge clock) begin
      if (ctl.en[0]) begin
         prod_ff  <= prod_in;
         cm_ff    <= cm_in;
         size1_ff <= size_in;
         sum_ff   <= sum_in;
      end
   end

   // Stage 2: split the power of two, table lookup, interpolation product, centre sum.
   logic signed [33:0] t16;
   logic signed [17:0] n_val, n_neg;
   logic [3:0]         idx;
   logic [11:0]        frac;
   logic [12:0]        diff;
   logic [17:0]        base_ff, base_in;
   logic [24:0]        ip_ff, ip_in;
   logic               sat2_ff, sat_in, left2_ff, left_in, zero2_ff, zero_in;
   logic [4:0]         sh2_ff, sh_in;
   logic signed [CW-1:0] ctr2_ff, ctr_in;
   logic signed [13:0] size2_ff;

   always_comb begin
      t16     = prod_ff >>> F;
      n_val   = t16[33:16];
      n_neg   = -n_val;
      idx     = t16[15:12];
      frac    = t16[11:0];
      base_in = bddc_pkg::EXP2_TAB[{1'b0, idx}];
      diff    = 13'(bddc_pkg::EXP2_TAB[5'({1'b0, idx} + 5'd1)] - base_in);
      ip_in   = diff * frac;
      sat_in  = n_val >= 18'sd16;
      left_in = n_val >= 18'sd0;
      zero_in = n_val < -18'sd17;
      sh_in   = left_in ? n_val[4:0] : n_neg[4:0];
      ctr_in  = $signed(CW'({sum_ff, {(F - 1){1'b0}}})) + CW'(cm_ff);
   end

   always_ff @(posedge clock) begin
      if (ctl.en[1]) begin
         base_ff  <= base_in;
         ip_ff    <= ip_in;
         sat2_ff  <= sat_in;
         left2_ff <= left_in;
         zero2_ff <= zero_in;
         sh2_ff   <= sh_in;
         ctr2_ff  <= ctr_in;
         size2_ff <= size1_ff;
      end
   end

   // Stage 3: interpolated mantissa, scaled by the power of two with saturation.
   logic [17:0] mant;
   logic [32:0] wide;
   logic [31:0] exp_ff, exp_in;
   logic signed [CW-1:0] ctr3_ff;
   logic signed [13:0]   size3_ff;

   always_comb begin
      mant = base_ff + 18'(ip_ff >> 12);
      wide = {15'd0, mant} << sh2_ff;
      if (sat2_ff) begin
         exp_in = '1;
      end else if (left2_ff) begin
         exp_in = wide[32] ? '1 : wide[31:0];
      end else if (zero2_ff) begin
         exp_in = '0;
      end else begin
         exp_in = {14'd0, mant >> sh2_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en[2]) begin
         exp_ff   <= exp_in;
         ctr3_ff  <= ctr2_ff;
         size3_ff <= size2_ff;
      end
   end

   // Stage 4: new size times exp.
   logic signed [PW-1:0] half_ff, half_in;
   logic signed [CW-1:0] ctr4_ff;

   assign half_in = $signed({1'b0, exp_ff}) * size3_ff;

   always_ff @(posedge clock) begin
      if (ctl.en[3]) begin
         half_ff <= half_in;
         ctr4_ff <= ctr3_ff;
      end
   end

   // Stage 5: edge numerators, centre minus and plus half the size.
   logic signed [NW-1:0] c_ext, h_ext;
   logic signed [NW-1:0] nlo_ff, nlo_in, nhi_ff, nhi_in;

   always_comb begin
      c_ext  = NW'(ctr4_ff) <<< 16;
      h_ext  = NW'(half_ff) <<< (F - 1);
      nlo_in = c_ext - h_ext;
      nhi_in = c_ext + h_ext;
   end

   always_ff @(posedge clock) begin
      if (ctl.en[4]) begin
         nlo_ff <= nlo_in;
         nhi_ff <= nhi_in;
      end
   end

   // Stage 6: divide by the scale, truncating toward zero.
   logic signed [NW-1:0] rlo, rhi;
   logic signed [EW-1:0] elo_ff, elo_in, ehi_ff, ehi_in;

   always_comb begin
      rlo    = nlo_ff + $signed(nlo_ff[NW-1] ? RND : '0);
      rhi    = nhi_ff + $signed(nhi_ff[NW-1] ? RND : '0);
      elo_in = EW'(rlo >>> (F + 16));
      ehi_in = EW'(rhi >>> (F + 16));
   end

   always_ff @(posedge clock) begin
      if (ctl.en[5]) begin
         elo_ff <= elo_in;
         ehi_ff <= ehi_in;
      end
   end

   // Stage 7: clip to the image, then saturate to 16 bits.
   logic signed [EW-1:0] lo_pos, hi_clip, bound_ext;
   logic signed [15:0]   lo_ff, lo_in, hi_ff, hi_in;

   always_comb begin
      bound_ext = $signed(EW'(bound));
      lo_pos    = (elo_ff > 0) ? elo_ff : '0;
      hi_clip   = (ehi_ff < bound_ext) ? ehi_ff : bound_ext - EW'(1);
      lo_in     = (lo_pos > EW'(32767)) ? 16'sh7FFF : lo_pos[15:0];
      if (hi_clip > EW'(32767)) begin
         hi_in = 16'sh7FFF;
      end else if (hi_clip < -EW'(32768)) begin
         hi_in = 16'sh8000;
      end else begin
         hi_in = hi_clip[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en[6]) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   assign box_lo = lo_ff;
   assign box_hi = hi_ff;

endmodule

// ===== design/box_delta_decode_clip_unit.sv =====
// ----------------------------------------------------------------------------
// box_delta_decode_clip_unit
// Bounding box regression decode with clipping to the image and a size check.
// ----------------------------------------------------------------------------
// Usage: each beat on the req_ channel carries one proposal box with one
// class's four regression deltas and its score. Each accepted beat produces
// exactly one beat on the rsp_ channel with the decoded, clipped box and the
// score, which is forced to zero when the box is narrower or shorter than the
// minimum size. Results leave in the order in which the beats arrived.
// The datapath is an eight-stage pipeline and takes one beat every cycle
// until a stalled rsp_tready has filled it. The depth
// is set by the exp approximation (multiply, table lookup and interpolation,
// shift) followed by the size multiply, the edge sums and the clip.
// Each stage has a valid bit and moves forward when the stage after it is
// empty or moving, so a stalled rsp_tready fills the bubbles first and then
// holds every stage; req_tready falls only once the whole pipeline is full.
// Reset empties the pipeline and restores the image size to 640 by 480 and
// the minimum box size to 32. The csr_ registers take effect at once and are
// meant to be written only while the pipeline is empty.
// ----------------------------------------------------------------------------
module box_delta_decode_clip_unit #(
   parameter int DELTA_FRAC_BITS = 12
) (
   input  logic         clock,
   input  logic         reset,
   // prop_left, prop_top, prop_right, prop_bottom (12 bits each),
   // delta_cx, delta_cy, delta_logw, delta_logh, class_score (16 bits each)
   input  logic [127:0] req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // box_left, box_top, box_right, box_bottom, score_out (16 bits each)
   output logic [79:0]  rsp_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [12:0]  csr_wdata
);

   localparam int NS = bddc_pkg::NUM_STAGES;

   // Configuration registers.
   logic [12:0] rows_ff, cols_ff;
   logic [11:0] min_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff     <= bddc_pkg::IMAGE_ROWS_RESET;
         cols_ff     <= bddc_pkg::IMAGE_COLS_RESET;
         min_size_ff <= bddc_pkg::MIN_BOX_SIZE_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            bddc_pkg::CSR_IMAGE_ROWS:   rows_ff     <= csr_wdata;
            bddc_pkg::CSR_IMAGE_COLS:   cols_ff     <= csr_wdata;
            bddc_pkg::CSR_MIN_BOX_SIZE: min_size_ff <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // Flow control. Stage k (bit k-1) loads when it is empty or when the
   // stage after it moves on; the last stage moves on when the receiver takes
   // the beat. The enable chain is a short ripple over eight stages.
   logic [NS-1:0] valid_ff, valid_in;
   logic [NS-1:0] en;

   always_comb begin
      en[NS-1] = !valid_ff[NS-1] || rsp_tready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      if (en[0]) begin
         valid_in[0] = req_tvalid;
      end else begin
         valid_in[0] = valid_ff[0];
      end
      for (int k = 1; k < NS; k++) begin
         if (en[k]) begin
            valid_in[k] = valid_ff[k-1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = valid_ff[NS-1];

   // Unpack the request beat.
   logic [11:0]        prop_left, prop_top, prop_right, prop_bottom;
   logic signed [15:0] delta_cx, delta_cy, delta_logw, delta_logh;
   logic [15:0]        class_score;

   assign prop_left   = req_tdata[11:0];
   assign prop_top    = req_tdata[23:12];
   assign prop_right  = req_tdata[35:24];
   assign prop_bottom = req_tdata[47:36];
   assign delta_cx    = $signed(req_tdata[63:48]);
   assign delta_cy    = $signed(req_tdata[79:64]);
   assign delta_logw  = $signed(req_tdata[95:80]);
   assign delta_logh  = $signed(req_tdata[111:96]);
   assign class_score = req_tdata[127:112];

   // Both axes run side by side under the same stage enables.
   bddc_pkg::axis_ctl_type axis_ctl;
   logic signed [15:0] left_s7, right_s7, top_s7, bottom_s7;

   assign axis_ctl.en = en[bddc_pkg::AXIS_STAGES-1:0];

   bddc_axis #(
      .DELTA_FRAC_BITS(DELTA_FRAC_BITS)
   ) u_axis_x (
      .clock     (clock),
      .ctl       (axis_ctl),
      .prop_lo   (prop_left),
      .prop_hi   (prop_right),
      .delta_ctr (delta_cx),
      .delta_log (delta_logw),
      .bound     (cols_ff),
      .box_lo    (left_s7),
      .box_hi    (right_s7)
   );

   bddc_axis #(
      .DELTA_FRAC_BITS(DELTA_FRAC_BITS)
   ) u_axis_y (
      .clock     (clock),
      .ctl       (axis_ctl),
      .prop_lo   (prop_top),
      .prop_hi   (prop_bottom),
      .delta_ctr (delta_cy),
      .delta_log (delta_logh),
      .bound     (rows_ff),
      .box_lo    (top_s7),
      .box_hi    (bottom_s7)
   );

   // The score rides alongside the axis stages.
   logic [15:0] score_ff [bddc_pkg::AXIS_STAGES];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         score_ff[0] <= class_score;
      end
      for (int k = 1; k < bddc_pkg::AXIS_STAGES; k++) begin
         if (en[k]) begin
            score_ff[k] <= score_ff[k-1];
         end
      end
   end

   // Output stage: size check on the clipped edges, then the result register.
   logic signed [16:0] width_s, height_s, min_s;
   logic               too_small;
   logic [79:0]        rsp_data_ff, rsp_data_in;

   always_comb begin
      width_s     = 17'(right_s7) - 17'(left_s7);
      height_s    = 17'(bottom_s7) - 17'(top_s7);
      min_s       = $signed({5'd0, min_size_ff});
      too_small   = (width_s < min_s) || (height_s < min_s);
      rsp_data_in = {too_small ? 16'd0 : score_ff[bddc_pkg::AXIS_STAGES-1],
                     bottom_s7, right_s7, top_s7, left_s7};
   end

   always_ff @(posedge clock) begin
      if (en[NS-1]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

// ===== tb/sv/box_delta_decode_clip_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_delta_decode_clip_unit_test
// Self-checking bench for the box delta decode and clip unit. Proposal beats
// come from a queue, results are compared field by field against a local
// fixed-point decoder, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module box_delta_decode_clip_unit_test;

   localparam int DELTA_FRAC_BITS = 12;

   // The control port decodes two address bits but maps only three of the
   // four codes. The spare one is written now and then and must be ignored.
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;

   // The bench's own fixed-point constants for exp(). log2(e) carries 16
   // fraction bits, and the mantissa table holds 2^(k/16) for k = 0..16.
   localparam longint LOG2E_SCALED = 94548;
   localparam longint EXP_CEILING  = 64'h0000_0000_FFFF_FFFF;
   localparam longint EXP2_Q16 [17] = '{
      65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752, 92682,
      96785, 101070, 105545, 110218, 115098, 120194, 125515, 131072
   };
   // A center or half size is held with DELTA_FRAC_BITS + 16 fraction bits.
   localparam longint HALF_DELTA_ONE = longint'(1) << (DELTA_FRAC_BITS - 1);
   localparam longint EDGE_ONE       = longint'(1) << (DELTA_FRAC_BITS + 16);

   localparam int RANDOM_PHASES    = 6;
   localparam int BEATS_PER_PHASE  = 192;
   localparam int IDLE_PERCENT     = 17;
   localparam int HOLD_AFTER_BEATS = 300;
   localparam int HOLD_CYCLES      = 150;
   localparam int WATCHDOG_LIMIT   = 2000;

   // One request beat. Packed from the top down so that the first field
   // lands in the lowest bits of req_tdata.
   typedef struct packed {
      logic [15:0]        class_score;
      logic signed [15:0] delta_logh;
      logic signed [15:0] delta_logw;
      logic signed [15:0] delta_cy;
      logic signed [15:0] delta_cx;
      logic [11:0]        prop_bottom;
      logic [11:0]        prop_right;
      logic [11:0]        prop_top;
      logic [11:0]        prop_left;
   } proposal_beat_type;

   // One response beat, laid out as rsp_tdata.
   typedef struct packed {
      logic [15:0]        score_out;
      logic signed [15:0] box_bottom;
      logic signed [15:0] box_right;
      logic signed [15:0] box_top;
      logic signed [15:0] box_left;
   } result_beat_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   // prop_left, prop_top, prop_right, prop_bottom (12 bits each),
   // delta_cx, delta_cy, delta_logw, delta_logh, class_score (16 bits each)
   logic [127:0] req_tdata  = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // box_left, box_top, box_right, box_bottom, score_out (16 bits each)
   logic [79:0]  rsp_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic         csr_we     = 1'b0;
   logic [1:0]   csr_addr   = '0;
   logic [12:0]  csr_wdata  = '0;

   // The bench's copy of the image bounds and the minimum box size.
   logic [12:0] rows_limit     = bddc_pkg::IMAGE_ROWS_RESET;
   logic [12:0] cols_limit     = bddc_pkg::IMAGE_COLS_RESET;
   logic [11:0] min_size_limit = bddc_pkg::MIN_BOX_SIZE_RESET;

   proposal_beat_type pending_proposals [$];
   proposal_beat_type offered_proposal;
   result_beat_type   expected_boxes [$];
   logic [79:0]       expected_bits;

   // Set for one whole phase so that neither side idles during it.
   bit quiet_stretch = 1'b0;
   bit long_hold_done = 1'b0;
   int hold_left = 0;
   int results_checked = 0;
   int mismatches = 0;
   int stalled_cycles = 0;

   string result_field_name [5] = '{"box_left", "box_top", "box_right", "box_bottom",
                                    "score_out"};

   box_delta_decode_clip_unit #(
      .DELTA_FRAC_BITS(DELTA_FRAC_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Decoder used to work out the expected boxes.
   // ------------------------------------------------------------------------

   // exp(d) for a delta with DELTA_FRAC_BITS fraction bits, as unsigned Q16.16.
   // It is evaluated as 2^(d * log2 e): the integer part of the exponent is a
   // shift and the fraction picks a table entry, interpolated linearly on its
   // low 12 bits. Every rounding step floors.
   function automatic longint exp_q16(input longint delta);
      longint exponent, whole, frac, slot, tail, mantissa, scaled;
      exponent = (delta * LOG2E_SCALED) >>> DELTA_FRAC_BITS;
      whole    = exponent >>> 16;
      frac     = exponent - (whole <<< 16);
      slot     = frac >>> 12;
      tail     = frac & 4095;
      mantissa = EXP2_Q16[slot] + (((EXP2_Q16[slot + 1] - EXP2_Q16[slot]) * tail) >>> 12);
      if (whole >= 16)
         return EXP_CEILING;
      if (whole >= 0)
         scaled = mantissa <<< whole;
      else if (whole <= -40)
         scaled = 0;
      else
         scaled = mantissa >>> (-whole);
      return (scaled > EXP_CEILING) ? EXP_CEILING : scaled;
   endfunction

   // One axis: the center moves by delta times size, the size grows by
   // exp(log delta). An inverted proposal gives a zero or negative size and
   // simply runs through the signed arithmetic. Edges truncate toward zero,
   // which is what signed division does here.
   function automatic void decode_axis(input longint low_in, input longint high_in,
                                       input longint shift, input longint log_scale,
                                       output longint low_edge, output longint high_edge);
      longint size, center, half;
      size      = high_in - low_in + 1;
      center    = ((low_in + high_in) * HALF_DELTA_ONE + shift * size) * 65536;
      half      = exp_q16(log_scale) * size * HALF_DELTA_ONE;
      low_edge  = (center - half) / EDGE_ONE;
      high_edge = (center + half) / EDGE_ONE;
   endfunction

   function automatic longint saturate16(input longint value);
      if (value > 32767)
         return 32767;
      if (value < -32768)
         return -32768;
      return value;
   endfunction

   // Full decode of one proposal under the current register copy. Left and top
   // are clamped at zero, right and bottom at the image bound minus one (a
   // bound of zero gives -1), then every edge saturates to 16 bits. The size
   // test works on the saturated edges.
   function automatic result_beat_type predict_box(input proposal_beat_type prop);
      result_beat_type box;
      longint left_e, top_e, right_e, bottom_e, cols, rows;
      cols = longint'(cols_limit);
      rows = longint'(rows_limit);
      decode_axis(prop.prop_left, prop.prop_right, prop.delta_cx, prop.delta_logw,
                  left_e, right_e);
      decode_axis(prop.prop_top, prop.prop_bottom, prop.delta_cy, prop.delta_logh,
                  top_e, bottom_e);
      left_e   = saturate16((left_e > 0) ? left_e : 0);
      top_e    = saturate16((top_e > 0) ? top_e : 0);
      right_e  = saturate16((right_e < cols) ? right_e : cols - 1);
      bottom_e = saturate16((bottom_e < rows) ? bottom_e : rows - 1);
      box.box_left   = 16'(left_e);
      box.box_top    = 16'(top_e);
      box.box_right  = 16'(right_e);
      box.box_bottom = 16'(bottom_e);
      if (right_e - left_e < longint'(min_size_limit) ||
          bottom_e - top_e < longint'(min_size_limit))
         box.score_out = '0;
      else
         box.score_out = prop.class_score;
      return box;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------------

   function automatic proposal_beat_type make_proposal(
         input int left, input int top, input int right, input int bottom,
         input int shift_x, input int shift_y, input int scale_w, input int scale_h,
         input int score);
      proposal_beat_type prop;
      prop.prop_left   = 12'(left);
      prop.prop_top    = 12'(top);
      prop.prop_right  = 12'(right);
      prop.prop_bottom = 12'(bottom);
      prop.delta_cx    = 16'(shift_x);
      prop.delta_cy    = 16'(shift_y);
      prop.delta_logw  = 16'(scale_w);
      prop.delta_logh  = 16'(scale_h);
      prop.class_score = 16'(score);
      return prop;
   endfunction

   // Appends one beat to the queue that feeds the driver.
   function automatic void add_pending(input proposal_beat_type prop);
      pending_proposals = {pending_proposals, prop};
   endfunction

   // Most beats look like real detector output: an ordered box of modest size
   // with deltas within +/-0.5 for the center and +/-2.5 for log size.
   // The rest are raw random bits, and some of those are forced inverted.
   function automatic proposal_beat_type random_proposal();
      proposal_beat_type prop;
      int unsigned span_x, span_y;
      prop = {$urandom, $urandom, $urandom, $urandom};
      case ($urandom_range(9))
         0, 1: begin
         end
         2: begin
            prop.prop_right  = 12'($urandom_range(prop.prop_left));
            prop.prop_bottom = 12'($urandom_range(prop.prop_top));
         end
         default: begin
            span_x = $urandom_range(5) == 0 ? $urandom_range(4095) : $urandom_range(200);
            span_y = $urandom_range(5) == 0 ? $urandom_range(4095) : $urandom_range(200);
            prop.prop_left   = 12'($urandom_range(4095 - span_x));
            prop.prop_top    = 12'($urandom_range(4095 - span_y));
            prop.prop_right  = prop.prop_left + 12'(span_x);
            prop.prop_bottom = prop.prop_top + 12'(span_y);
            prop.delta_cx    = 16'(int'($urandom_range(4096)) - 2048);
            prop.delta_cy    = 16'(int'($urandom_range(4096)) - 2048);
            prop.delta_logw  = 16'(int'($urandom_range(20480)) - 10240);
            prop.delta_logh  = 16'(int'($urandom_range(20480)) - 10240);
         end
      endcase
      return prop;
   endfunction

   // Writes one register and keeps the bench's copy in step. The caller drops
   // the write enable after its last write.
   task automatic write_register(input logic [1:0] index, input logic [12:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         bddc_pkg::CSR_IMAGE_ROWS:   rows_limit = value;
         bddc_pkg::CSR_IMAGE_COLS:   cols_limit = value;
         bddc_pkg::CSR_MIN_BOX_SIZE: min_size_limit = value[11:0];
         default: ;
      endcase
   endtask

   task automatic set_registers(input logic [12:0] rows, input logic [12:0] cols,
                                input logic [12:0] min_size);
      write_register(bddc_pkg::CSR_IMAGE_ROWS, rows);
      write_register(CSR_UNMAPPED, 13'($urandom));
      write_register(bddc_pkg::CSR_IMAGE_COLS, cols);
      write_register(bddc_pkg::CSR_MIN_BOX_SIZE, min_size);
      csr_we <= 1'b0;
   endtask

   // Registers may only change with the pipeline empty, so this waits until
   // every queued beat has gone in and every expected box has come back. The
   // test is made on the falling edge, once the clocked processes have
   // settled, and the task returns on the following rising edge.
   task automatic wait_until_drained();
      while (pending_proposals.size() != 0 || req_tvalid || expected_boxes.size() != 0)
         @(negedge clock);
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Request driver. A new beat is loaded whenever the slot is free, unless
   // the sender decides to idle this cycle. The expected box is computed when
   // the beat is actually taken, using the register copy of that moment.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_boxes = {expected_boxes, predict_box(offered_proposal)};
         if (!req_tvalid || req_tready) begin
            if (pending_proposals.size() != 0 &&
                (quiet_stretch || $urandom_range(99) >= IDLE_PERCENT)) begin
               offered_proposal = pending_proposals.pop_front();
               req_tdata  <= offered_proposal;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor. Each beat taken is matched against the oldest expected
   // box. Once, after a few hundred results, the receiver holds off for a long
   // stretch while the sender keeps offering, so the pipeline fills and
   // req_tready has to fall.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_checked++;
            if (expected_boxes.size() == 0) begin
               $display("%0d ns: unexpected result beat, expected none, got %h",
                        $time, rsp_tdata);
               mismatches++;
            end else begin
               expected_bits = expected_boxes.pop_front();
               for (int k = 0; k < 5; k++) begin
                  if (rsp_tdata[16*k +: 16] !== expected_bits[16*k +: 16]) begin
                     $display("%0d ns: %s expected 16'h%h, got 16'h%h", $time,
                              result_field_name[k], expected_bits[16*k +: 16],
                              rsp_tdata[16*k +: 16]);
                     mismatches++;
                  end
               end
            end
         end
         if (!long_hold_done && results_checked == HOLD_AFTER_BEATS) begin
            long_hold_done = 1'b1;
            hold_left      = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet_stretch || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // Watchdog: a long run of cycles with no beat on either channel means the
   // block has hung or dropped a result.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("%0d ns: watchdog, no beat for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed beats under the reset image of 640 by 480, minimum size 32.
      // Extremes of every field first.
      add_pending(make_proposal(0, 0, 0, 0, 0, 0, 0, 0, 0));
      add_pending(make_proposal(4095, 4095, 4095, 4095,
                                32767, 32767, 32767, 32767, 65535));
      add_pending(make_proposal(0, 0, 4095, 4095,
                                -32768, -32768, -32768, -32768, 65535));
      add_pending(make_proposal(12'hAAA, 12'h555, 12'hAAA, 12'h555,
                                16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555,
                                16'h5A5A));
      // A plain box with no correction, then a small one with fractional deltas.
      add_pending(make_proposal(100, 120, 300, 260, 0, 0, 0, 0, 16'hABCD));
      add_pending(make_proposal(50, 60, 90, 110, 100, -100, 200, -200, 1));
      // Size test right at the minimum: kept, too narrow, too short.
      add_pending(make_proposal(100, 100, 131, 131, 0, 0, 0, 0, 16'h8000));
      add_pending(make_proposal(100, 100, 130, 131, 0, 0, 0, 0, 16'h8000));
      add_pending(make_proposal(100, 100, 131, 130, 0, 0, 0, 0, 16'h8000));
      // Inverted and zero-size proposals.
      add_pending(make_proposal(300, 200, 100, 50, 512, -512, 1024, -1024,
                                16'h1234));
      add_pending(make_proposal(200, 200, 199, 199, 0, 0, 0, 0, 16'hFFFF));
      // Inverted with a huge scale: the edges run past 16 bits and saturate.
      add_pending(make_proposal(4095, 4095, 0, 0, 0, 0, 32767, 32767,
                                16'h7777));
      // Center pushed off the low side, then past the right and bottom bounds.
      add_pending(make_proposal(10, 10, 60, 60, -32768, -32768, 0, 0,
                                16'h4444));
      add_pending(make_proposal(600, 440, 639, 479, 32767, 32767, 0, 0,
                                16'h4444));
      // Edges that land exactly on the image bound.
      add_pending(make_proposal(600, 440, 640, 480, 0, 0, 0, 0, 16'h2222));
      // Scale up until both sides clip, and scale down to almost nothing.
      add_pending(make_proposal(300, 200, 340, 240, 0, 0, 16384, 16384,
                                16'h3333));
      add_pending(make_proposal(300, 200, 340, 240, 0, 0, -32767, -32767,
                                16'h3333));
      // Deltas with every fraction bit set, positive and negative.
      add_pending(make_proposal(20, 30, 400, 300, 16'h0FFF, 16'hF001,
                                16'h0FFF, 16'hF001, 16'hC000));
      wait_until_drained();

      // Random phases, each under its own register setting. Small and large values
      // of every register are visited, including a zero row bound and a minimum
      // size written with bit 12 set, which the 12-bit register drops.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: set_registers(13'd4096, 13'd4096, 13'd0);
            1: set_registers(13'd1, 13'd1, 13'd0);
            2: set_registers(13'd0, 13'h1FFF, 13'h1FFF);
            3: set_registers(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)),
                             13'($urandom_range(64)));
            4: set_registers(13'd720, 13'd1280, 13'd16);
            default: set_registers(13'd4096, 13'd1, 13'd4095);
         endcase
         // One phase runs back to back on both channels.
         quiet_stretch = (phase == 4);
         for (int n = 0; n < BEATS_PER_PHASE; n++)
            add_pending(random_proposal());
         wait_until_drained();
      end
      quiet_stretch = 1'b0;

      // Give a stray late beat time to show up before the verdict.
      repeat (2 * bddc_pkg::NUM_STAGES) @(posedge clock);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== box_delta_decode_clip_unit.f =====
design/bddc_pkg.sv
design/bddc_axis.sv
design/box_delta_decode_clip_unit.sv
tb/sv/box_delta_decode_clip_unit_test.sv
